// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the scheduler, tlfs_checker.sv.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check with a label and a message.
`define TLFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define TLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `TLFS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: sv/tlfs_pkg.sv
// Package of the three-level feedback scheduler: field widths, codes and reset values.
// No dependencies; every other file of the block but assert_macros.svh imports it.
package tlfs_pkg;

  // Field widths of the words on the channels and the configuration port.
  localparam int ProcIdW   = 4;
  localparam int BurstW    = 12;
  localparam int QuantW    = 12;
  localparam int EventW    = 3;
  localparam int LevelW    = 2;
  localparam int NumLevels = 3;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 12;

  // Quantum values after reset.
  localparam logic [QuantW-1:0] QuantOneRst   = 12'd6;
  localparam logic [QuantW-1:0] QuantTwoRst   = 12'd12;
  localparam logic [QuantW-1:0] QuantThreeRst = 12'd1024;

  // Kind of input word.
  typedef enum logic {
    OpTick  = 1'b0,
    OpReady = 1'b1
  } op_e;

  // Event reported with each result word.
  typedef enum logic [EventW-1:0] {
    EvNone      = 3'd0,
    EvDone      = 3'd1,
    EvDemoted   = 3'd2,
    EvPreempted = 3'd3,
    EvRejected  = 3'd4
  } event_e;

  // Queue levels; zero means no level.
  typedef enum logic [LevelW-1:0] {
    LvlNone  = 2'd0,
    LvlOne   = 2'd1,
    LvlTwo   = 2'd2,
    LvlThree = 2'd3
  } level_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgQuantOne   = 2'd0,
    CfgQuantTwo   = 2'd1,
    CfgQuantThree = 2'd2
  } cfg_idx_e;

endpackage

// File: sv/tlfs_in_if.sv
// Input channel of the scheduler: valid/ready handshake with one input word.
// Depends on tlfs_pkg for the field widths.
interface tlfs_in_if import tlfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [ProcIdW-1:0]   proc_id;
  logic [BurstW-1:0]    burst_len;

  modport source (output valid, op, proc_id, burst_len, input ready);
  modport sink   (input valid, op, proc_id, burst_len, output ready);
endinterface

// File: sv/tlfs_out_if.sv
// Result channel of the scheduler: valid/ready handshake with one result word.
// Depends on tlfs_pkg for the field widths.
interface tlfs_out_if import tlfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 ran_valid;
  logic [ProcIdW-1:0]   ran_id;
  logic                 dispatched;
  logic [EventW-1:0]    event_res;
  logic [LevelW-1:0]    ran_level;

  modport source (output valid, ran_valid, ran_id, dispatched, event_res, ran_level,
                  input ready);
  modport sink   (input valid, ran_valid, ran_id, dispatched, event_res, ran_level,
                  output ready);
endinterface

// File: sv/three_level_feedback_scheduler.sv
// Top level of the three-level feedback scheduler, built on tlfs_pkg, tlfs_in_if and
// tlfs_out_if. Holds the level queues, per-process state and the running process.
//
// Three-level feedback-queue dispatcher. A ready word enqueues a process at the level it
// last ran at (level one when new); a tick word dispatches the head of the highest
// non-empty level when the CPU is idle, runs the current process for one unit and reports
// burst completion, demotion on quantum expiry, or preemption by a higher level. Every word
// gives exactly one result word. The block takes one word per clock cycle while the result
// channel does not stall it; a word passes through the input register and then the result
// register, and the queue and process update is made as the word leaves the input register.
// Only process numbers below NUM_PROCS are accepted, and queue and process storage is sized
// for the smaller of NUM_PROCS and the sixteen numbers a proc_id can carry. Quantum registers
// are meant to be written while no word is in flight.
module three_level_feedback_scheduler import tlfs_pkg::*; #(
  parameter int NUM_PROCS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tlfs_in_if.sink             in_ch,
  tlfs_out_if.source          out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int MaxIds   = 2 ** ProcIdW;
  localparam int NumSlots = (NUM_PROCS < MaxIds) ? NUM_PROCS : MaxIds;
  localparam int SlotW    = $clog2(NumSlots);
  localparam int CntW     = $clog2(NumSlots + 1);
  localparam int SumW     = CntW + 1;
  localparam int IdLimW   = ProcIdW + 1;
  localparam logic [IdLimW-1:0] IdLimit  = IdLimW'(NumSlots);
  localparam logic [SumW-1:0]   SlotsV   = SumW'(NumSlots);
  localparam logic [SlotW-1:0]  LastSlot = SlotW'(NumSlots - 1);

  // Quantum registers.
  logic [QuantW-1:0] quant_q [NumLevels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q[0] <= QuantOneRst;
      quant_q[1] <= QuantTwoRst;
      quant_q[2] <= QuantThreeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgQuantOne:   quant_q[0] <= cfg_data_i[QuantW-1:0];
        CfgQuantTwo:   quant_q[1] <= cfg_data_i[QuantW-1:0];
        CfgQuantThree: quant_q[2] <= cfg_data_i[QuantW-1:0];
        default: ;
      endcase
    end
  end

  // Input register and result register handshake.
  logic                in_valid_q;
  op_e                 in_op_q;
  logic [ProcIdW-1:0]  in_pid_q;
  logic [BurstW-1:0]   in_blen_q;
  logic                out_valid_q;
  logic                advance;
  logic                in_acc;

  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_acc || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && !out_ch.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_op_q   <= op_e'(in_ch.op);
      in_pid_q  <= in_ch.proc_id;
      in_blen_q <= in_ch.burst_len;
    end
  end

  // Queue and process state.
  logic [SlotW-1:0]  fifo_q  [NumLevels][NumSlots];
  logic [SlotW-1:0]  head_q  [NumLevels];
  logic [CntW-1:0]   cnt_q   [NumLevels];
  level_e            plevel_q [NumSlots];
  logic [NumSlots-1:0] present_q;
  logic [BurstW-1:0] rem_q   [NumSlots];
  logic              run_valid_q;
  logic [SlotW-1:0]  run_id_q;
  level_e            run_level_q;
  logic [QuantW-1:0] quant_left_q;
  logic [BurstW-1:0] burst_left_q;

  // Next-state and result signals.
  logic              run_valid_d;
  logic [SlotW-1:0]  run_id_d;
  level_e            run_level_d;
  logic [QuantW-1:0] quant_left_d;
  logic [BurstW-1:0] burst_left_d;
  logic              do_pop;
  logic [LevelW-1:0] pop_sel;
  logic              do_push;
  logic [LevelW-1:0] push_sel;
  logic [SlotW-1:0]  push_id;
  logic [SlotW-1:0]  push_slot;
  logic [SumW-1:0]   tail_sum;
  logic              rem_we;
  logic [SlotW-1:0]  rem_idx;
  logic [BurstW-1:0] rem_wdata;
  logic              lvl_we;
  logic              pres_set;
  logic              pres_clr;
  logic [SlotW-1:0]  pidx;
  logic              in_range;
  level_e            ready_lvl;
  logic [NumLevels-1:0] non_empty;
  logic [LevelW-1:0] sel;
  logic              disp;
  logic [SlotW-1:0]  cur_id;
  level_e            cur_lvl;
  logic [BurstW-1:0] cur_burst;
  logic [QuantW-1:0] cur_quant;
  logic [BurstW-1:0] bdec;
  logic [QuantW-1:0] qdec;
  logic              one_left;
  logic              two_left;
  logic              res_ran_valid;
  logic              res_dispatched;
  event_e            res_event;
  level_e            res_level;

  // Per-item update: admission of ready words, dispatch and one unit of run on ticks.
  always_comb begin
    pidx      = SlotW'(in_pid_q);
    in_range  = IdLimW'(in_pid_q) < IdLimit;
    ready_lvl = (plevel_q[pidx] == LvlNone) ? LvlOne : plevel_q[pidx];
    for (int l = 0; l < NumLevels; l++) begin
      non_empty[l] = cnt_q[l] != '0;
    end
    if (non_empty[0]) begin
      sel = LevelW'(0);
    end else if (non_empty[1]) begin
      sel = LevelW'(1);
    end else begin
      sel = LevelW'(2);
    end
    disp = !run_valid_q && (non_empty != '0);

    cur_id    = disp ? fifo_q[sel][head_q[sel]] : run_id_q;
    cur_lvl   = disp ? level_e'(sel + LevelW'(1)) : run_level_q;
    cur_burst = disp ? rem_q[cur_id] : burst_left_q;
    cur_quant = disp ? quant_q[sel] : quant_left_q;
    bdec      = (cur_burst == '0) ? '0 : cur_burst - BurstW'(1);
    qdec      = (cur_quant == '0) ? '0 : cur_quant - QuantW'(1);
    // Higher levels still holding work after this tick's pop.
    one_left  = non_empty[0] && !(disp && sel == LevelW'(0) && cnt_q[0] == CntW'(1));
    two_left  = non_empty[1] && !(disp && sel == LevelW'(1) && cnt_q[1] == CntW'(1));

    res_ran_valid  = 1'b0;
    res_dispatched = 1'b0;
    res_event      = EvNone;
    res_level      = LvlNone;
    do_pop         = 1'b0;
    pop_sel        = sel;
    do_push        = 1'b0;
    push_sel       = LevelW'(ready_lvl) - LevelW'(1);
    push_id        = pidx;
    rem_we         = 1'b0;
    rem_idx        = pidx;
    rem_wdata      = (in_blen_q == '0) ? BurstW'(1) : in_blen_q;
    lvl_we         = 1'b0;
    pres_set       = 1'b0;
    pres_clr       = 1'b0;
    run_valid_d    = run_valid_q;
    run_id_d       = run_id_q;
    run_level_d    = run_level_q;
    quant_left_d   = quant_left_q;
    burst_left_d   = burst_left_q;

    if (advance) begin
      if (in_op_q == OpReady) begin
        if (!in_range || present_q[pidx]) begin
          res_event = EvRejected;
        end else begin
          pres_set = 1'b1;
          rem_we   = 1'b1;
          do_push  = 1'b1;
        end
      end else if (disp || run_valid_q) begin
        res_ran_valid  = 1'b1;
        res_dispatched = disp;
        res_level      = cur_lvl;
        do_pop         = disp;
        lvl_we         = disp;
        run_valid_d    = 1'b1;
        run_id_d       = cur_id;
        run_level_d    = cur_lvl;
        quant_left_d   = qdec;
        burst_left_d   = bdec;
        push_id        = cur_id;
        rem_idx        = cur_id;
        rem_wdata      = bdec;
        if (bdec == '0) begin
          res_event   = EvDone;
          pres_clr    = 1'b1;
          run_valid_d = 1'b0;
        end else if (qdec == '0) begin
          res_event   = EvDemoted;
          rem_we      = 1'b1;
          do_push     = 1'b1;
          push_sel    = (cur_lvl == LvlOne) ? LevelW'(1) : LevelW'(2);
          run_valid_d = 1'b0;
        end else if ((cur_lvl == LvlTwo && one_left) ||
                     (cur_lvl == LvlThree && (one_left || two_left))) begin
          res_event   = EvPreempted;
          rem_we      = 1'b1;
          do_push     = 1'b1;
          push_sel    = LevelW'(cur_lvl) - LevelW'(1);
          run_valid_d = 1'b0;
        end
      end
    end

    // Tail slot of the pushed queue, from the state before any pop this cycle.
    tail_sum = SumW'(head_q[push_sel]) + SumW'(cnt_q[push_sel]);
    if (tail_sum >= SlotsV) begin
      tail_sum = tail_sum - SlotsV;
    end
    push_slot = tail_sum[SlotW-1:0];
  end

  // Queue entries and remaining bursts hold no reset value.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[push_sel][push_slot] <= push_id;
    end
    if (rem_we) begin
      rem_q[rem_idx] <= rem_wdata;
    end
  end

  // Queue pointers, counts and per-process control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NumLevels; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
      for (int p = 0; p < NumSlots; p++) begin
        plevel_q[p] <= LvlOne;
      end
      present_q    <= '0;
      run_valid_q  <= 1'b0;
      run_id_q     <= '0;
      run_level_q  <= LvlNone;
      quant_left_q <= '0;
      burst_left_q <= '0;
    end else begin
      for (int l = 0; l < NumLevels; l++) begin
        if (do_pop && pop_sel == LevelW'(l)) begin
          head_q[l] <= (head_q[l] == LastSlot) ? '0 : head_q[l] + SlotW'(1);
        end
        case ({do_push && push_sel == LevelW'(l), do_pop && pop_sel == LevelW'(l)})
          2'b10:   cnt_q[l] <= cnt_q[l] + CntW'(1);
          2'b01:   cnt_q[l] <= cnt_q[l] - CntW'(1);
          default: ;
        endcase
      end
      if (lvl_we) begin
        plevel_q[cur_id] <= cur_lvl;
      end
      if (pres_set) begin
        present_q[pidx] <= 1'b1;
      end
      if (pres_clr) begin
        present_q[cur_id] <= 1'b0;
      end
      run_valid_q  <= run_valid_d;
      run_id_q     <= run_id_d;
      run_level_q  <= run_level_d;
      quant_left_q <= quant_left_d;
      burst_left_q <= burst_left_d;
    end
  end

  // Result register.
  logic              out_ran_valid_q;
  logic [ProcIdW-1:0] out_ran_id_q;
  logic              out_disp_q;
  event_e            out_event_q;
  level_e            out_level_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ran_valid_q <= res_ran_valid;
      out_ran_id_q    <= res_ran_valid ? ProcIdW'(cur_id) : '0;
      out_disp_q      <= res_dispatched;
      out_event_q     <= res_event;
      out_level_q     <= res_level;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.ran_valid  = out_ran_valid_q;
  assign out_ch.ran_id     = out_ran_id_q;
  assign out_ch.dispatched = out_disp_q;
  assign out_ch.event_res  = out_event_q;
  assign out_ch.ran_level  = out_level_q;

endmodule

// File: sv/tlfs_checker.sv
// Port-level checker for the three-level feedback scheduler, bound to its top level.
// Depends on tlfs_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module tlfs_checker import tlfs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               ran_valid_i,
  input logic [ProcIdW-1:0] ran_id_i,
  input logic               dispatched_i,
  input logic [EventW-1:0]  event_res_i,
  input logic [LevelW-1:0]  ran_level_i
);

  // A stalled result word keeps its contents.
  `TLFS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(ran_valid_i) && $stable(ran_id_i) && $stable(dispatched_i) && $stable(event_res_i) && $stable(ran_level_i), "result word changed while stalled")

  // Without a running process the process fields read as zero.
  `TLFS_ASSERT(a_idle_fields, out_valid_i && !ran_valid_i |-> ran_id_i == '0 && !dispatched_i && ran_level_i == LvlNone, "idle result carries process fields")

  // A process that ran has a level and was not a rejected ready word.
  `TLFS_ASSERT(a_ran_level, out_valid_i && ran_valid_i |-> ran_level_i != LvlNone && event_res_i != EvRejected, "running result lacks a level")

  // A dispatch always comes with a run.
  `TLFS_ASSERT(a_disp_runs, out_valid_i && dispatched_i |-> ran_valid_i, "dispatch without a run")

endmodule

bind three_level_feedback_scheduler tlfs_checker u_tlfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .ran_valid_i  (out_ch.ran_valid),
  .ran_id_i     (out_ch.ran_id),
  .dispatched_i (out_ch.dispatched),
  .event_res_i  (out_ch.event_res),
  .ran_level_i  (out_ch.ran_level)
);

// File: dv/tb_three_level_feedback_scheduler.sv
// Self-checking testbench of the three-level feedback scheduler: directed table, then random words.
// Depends on tlfs_pkg, tlfs_in_if, tlfs_out_if and three_level_feedback_scheduler.
module tb_three_level_feedback_scheduler;
  import tlfs_pkg::*;

  localparam int NumProcs   = 16;
  localparam int CycleLimit = 400000;
  localparam int PhaseWords = 460;
  localparam int DirRows    = 14;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  // One input word and one result word as the channels carry them.
  typedef struct packed {
    op_e                op;
    logic [ProcIdW-1:0] proc_id;
    logic [BurstW-1:0]  burst_len;
  } sched_word_t;

  typedef struct packed {
    logic               ran_valid;
    logic [ProcIdW-1:0] ran_id;
    logic               dispatched;
    event_e             event_res;
    level_e             ran_level;
  } sched_result_t;

  // A row of the directed table: the word, how often it repeats, and a typed-in result.
  typedef struct packed {
    op_e                op;
    logic [ProcIdW-1:0] proc_id;
    logic [BurstW-1:0]  burst_len;
    logic [3:0]         reps;
    logic               typed;
    sched_result_t      res;
  } dir_row_t;

  localparam sched_result_t NoRun  = '{1'b0, 4'd0, 1'b0, EvNone, LvlNone};
  localparam sched_result_t Reject = '{1'b0, 4'd0, 1'b0, EvRejected, LvlNone};

  localparam dir_row_t DirTab [DirRows] = '{
    '{OpTick,  4'd0,  12'd0,    4'd1, 1'b1, NoRun},   // idle CPU after reset
    '{OpReady, 4'd0,  12'd0,    4'd1, 1'b1, NoRun},   // zero burst is taken as one
    '{OpReady, 4'd0,  12'd5,    4'd1, 1'b1, Reject},  // process already held
    '{OpTick,  4'd0,  12'd4095, 4'd1, 1'b1, '{1'b1, 4'd0, 1'b1, EvDone, LvlOne}},
    '{OpReady, 4'd15, 12'd4095, 4'd1, 1'b1, NoRun},
    '{OpReady, 4'd15, 12'd1,    4'd1, 1'b1, Reject},
    '{OpReady, 4'd3,  12'd8,    4'd1, 1'b0, NoRun},
    '{OpTick,  4'd9,  12'd0,    4'd6, 1'b0, NoRun},   // first slice ends in demotion
    '{OpTick,  4'd0,  12'd0,    4'd6, 1'b0, NoRun},
    '{OpTick,  4'd0,  12'd0,    4'd1, 1'b0, NoRun},   // level two dispatch
    '{OpReady, 4'd7,  12'd2,    4'd1, 1'b0, NoRun},
    '{OpTick,  4'd0,  12'd0,    4'd1, 1'b0, NoRun},   // preempted by level one work
    '{OpTick,  4'd0,  12'd0,    4'd2, 1'b0, NoRun},
    '{OpTick,  4'd0,  12'd0,    4'd1, 1'b0, NoRun}
  };

  logic clk;
  logic rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tlfs_in_if  in_ch ();
  tlfs_out_if out_ch ();

  three_level_feedback_scheduler #(
    .NUM_PROCS(NumProcs)
  ) DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Shadow state of the dispatcher.
  logic [ProcIdW-1:0] lvl_fifo [NumLevels][NumProcs];
  int                 lvl_head [NumLevels];
  int                 lvl_cnt  [NumLevels];
  level_e             p_level  [NumProcs];
  logic               p_held   [NumProcs];
  logic [BurstW-1:0]  p_burst  [NumProcs];
  logic               cpu_busy;
  logic [ProcIdW-1:0] cpu_id;
  logic [QuantW-1:0]  slice_left;
  logic [BurstW-1:0]  burst_rem;
  logic [QuantW-1:0]  quantum [NumLevels];

  sched_result_t dispatch_reports_q [$];
  int mismatch_count;
  int cycle_count;
  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append a process to a level queue; a full queue drops it.
  function automatic void queue_push(level_e lvl, logic [ProcIdW-1:0] id);
    int q;
    q = int'(lvl) - 1;
    if (lvl_cnt[q] < NumProcs) begin
      lvl_fifo[q][(lvl_head[q] + lvl_cnt[q]) % NumProcs] = id;
      lvl_cnt[q]++;
    end
  endfunction

  // Advance the shadow dispatcher by one word and return the result it reports.
  function automatic sched_result_t schedule_step(sched_word_t w);
    sched_result_t r;
    int            idx;
    level_e        lv;
    r = NoRun;
    if (w.op == OpReady) begin
      if (int'(w.proc_id) >= NumProcs || p_held[w.proc_id]) begin
        r.event_res = EvRejected;
      end else begin
        p_held[w.proc_id]  = 1'b1;
        p_burst[w.proc_id] = (w.burst_len == '0) ? BurstW'(1) : w.burst_len;
        queue_push(p_level[w.proc_id], w.proc_id);
      end
    end else begin
      // An idle CPU takes the head of the highest non-empty level.
      if (!cpu_busy) begin
        idx = 0;
        while (idx < NumLevels && lvl_cnt[idx] == 0) idx++;
        if (idx < NumLevels) begin
          cpu_id        = lvl_fifo[idx][lvl_head[idx]];
          lvl_head[idx] = (lvl_head[idx] + 1) % NumProcs;
          lvl_cnt[idx]--;
          cpu_busy        = 1'b1;
          p_level[cpu_id] = level_e'(idx + 1);
          slice_left      = quantum[idx];
          burst_rem       = p_burst[cpu_id];
          r.dispatched    = 1'b1;
        end
      end
      // Run one unit, then check done, slice expiry and preemption in that order.
      if (cpu_busy) begin
        lv          = p_level[cpu_id];
        r.ran_valid = 1'b1;
        r.ran_id    = cpu_id;
        r.ran_level = lv;
        if (burst_rem != '0) burst_rem--;
        if (slice_left != '0) slice_left--;
        if (burst_rem == '0) begin
          r.event_res     = EvDone;
          p_held[cpu_id]  = 1'b0;
          p_burst[cpu_id] = '0;
          cpu_busy        = 1'b0;
        end else if (slice_left == '0) begin
          r.event_res     = EvDemoted;
          p_burst[cpu_id] = burst_rem;
          queue_push((lv == LvlOne) ? LvlTwo : LvlThree, cpu_id);
          cpu_busy        = 1'b0;
        end else if ((lv == LvlTwo && lvl_cnt[0] != 0) ||
                     (lv == LvlThree && (lvl_cnt[0] != 0 || lvl_cnt[1] != 0))) begin
          r.event_res     = EvPreempted;
          p_burst[cpu_id] = burst_rem;
          queue_push(lv, cpu_id);
          cpu_busy        = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Random word: mostly ticks and readies of absent processes with short bursts.
  function automatic sched_word_t random_word();
    sched_word_t w;
    int          pick;
    int          start;
    pick        = $urandom_range(99);
    w.proc_id   = ProcIdW'($urandom);
    w.burst_len = BurstW'($urandom);
    if (pick < 28) begin
      w.op = OpReady;
      if (pick < 24) begin
        start = $urandom_range(NumProcs - 1);
        for (int k = 0; k < NumProcs; k++) begin
          if (!p_held[(start + k) % NumProcs]) begin
            w.proc_id = ProcIdW'((start + k) % NumProcs);
            break;
          end
        end
      end
      pick = $urandom_range(99);
      if (pick < 3) w.burst_len = '0;
      else if (pick < 88) w.burst_len = BurstW'($urandom_range(1, 14));
      else if (pick < 99) w.burst_len = BurstW'($urandom_range(15, 60));
    end else begin
      w.op = OpTick;
    end
    return w;
  endfunction

  // Offer one word after a random gap; predict its result once it is accepted.
  // Starts and ends at a falling edge.
  task automatic send_word(input sched_word_t w, input logic typed, input sched_result_t res);
    sched_result_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= w.op;
    in_ch.proc_id   <= w.proc_id;
    in_ch.burst_len <= w.burst_len;
    do @(posedge clk); while (!in_ch.ready);
    pred = schedule_step(w);
    dispatch_reports_q.insert(dispatch_reports_q.size(), typed ? res : pred);
    @(negedge clk);
  endtask

  // Stop offering words until every predicted result has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    wait (dispatch_reports_q.size() == 0);
    @(negedge clk);
  endtask

  // Write the three quanta and the unused index, which must change nothing.
  task automatic write_quanta(input logic [QuantW-1:0] q1, input logic [QuantW-1:0] q2,
                              input logic [QuantW-1:0] q3);
    logic [CfgIdxW-1:0]  idx_tab  [4];
    logic [CfgDataW-1:0] data_tab [4];
    idx_tab  = '{CfgQuantOne, CfgQuantTwo, CfgQuantThree, CfgSpare};
    data_tab = '{q1, q2, q3, CfgDataW'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx_tab[i];
      cfg_data <= data_tab[i];
      if (i < NumLevels) quantum[i] = data_tab[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: random stalls, or a long hold when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Compare each result word with the oldest prediction.
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.ran_valid, out_ch.ran_id, out_ch.dispatched,
              event_e'(out_ch.event_res), level_e'(out_ch.ran_level)};
      if (dispatch_reports_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result word: rv=%0d id=%0d disp=%0d ev=%0d lvl=%0d",
                   got.ran_valid, got.ran_id, got.dispatched, got.event_res, got.ran_level);
        mismatch_count++;
      end else begin
        want = dispatch_reports_q.pop_front();
        if (got.ran_valid !== want.ran_valid || got.ran_id !== want.ran_id ||
            got.dispatched !== want.dispatched || got.event_res !== want.event_res ||
            got.ran_level !== want.ran_level) begin
          if (mismatch_count < 10) begin
            $write("mismatch: expected rv=%0d id=%0d disp=%0d ev=%0d lvl=%0d,",
                   want.ran_valid, want.ran_id, want.dispatched, want.event_res,
                   want.ran_level);
            $display(" got rv=%0d id=%0d disp=%0d ev=%0d lvl=%0d",
                     got.ran_valid, got.ran_id, got.dispatched,
                     got.event_res, got.ran_level);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sched_word_t w;
    in_ch.valid     = 1'b0;
    in_ch.op        = OpTick;
    in_ch.proc_id   = '0;
    in_ch.burst_len = '0;
    cfg_we          = 1'b0;
    cfg_idx         = CfgQuantOne;
    cfg_data        = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    hold_left       = 0;
    snd_idle_pct    = 22;
    rcv_idle_pct    = 73;
    rst_n           = 1'b0;

    // Shadow state after reset: queues empty, every process at level one.
    for (int i = 0; i < NumLevels; i++) begin
      lvl_head[i] = 0;
      lvl_cnt[i]  = 0;
    end
    for (int i = 0; i < NumProcs; i++) begin
      p_level[i] = LvlOne;
      p_held[i]  = 1'b0;
      p_burst[i] = '0;
    end
    cpu_busy   = 1'b0;
    cpu_id     = '0;
    slice_left = '0;
    burst_rem  = '0;
    quantum    = '{QuantOneRst, QuantTwoRst, QuantThreeRst};

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed table under the reset quanta.
    for (int i = 0; i < DirRows; i++) begin
      for (int n = 0; n < int'(DirTab[i].reps); n++) begin
        w = '{DirTab[i].op, DirTab[i].proc_id, DirTab[i].burst_len};
        send_word(w, DirTab[i].typed, DirTab[i].res);
      end
    end

    // Random phases, each with its own quanta and idling pattern.
    for (int p = 0; p < 3; p++) begin
      drain_results();
      case (p)
        0: begin
          write_quanta(12'd1, 12'd2, 12'd3);
          snd_idle_pct = 22;
          rcv_idle_pct = 73;
          hold_left    = 300;
        end
        1: begin
          write_quanta(12'd0, 12'd4095, 12'd0);
          snd_idle_pct = 73;
          rcv_idle_pct = 22;
        end
        default: begin
          write_quanta(QuantW'($urandom_range(1, 8)), QuantW'($urandom_range(1, 20)),
                       QuantW'($urandom_range(1, 4095)));
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PhaseWords; n++) begin
        w = random_word();
        send_word(w, 1'b0, NoRun);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && dispatch_reports_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
